@@ src/pfre_pkg.sv @@
// ----------------------------------------------------------------------------
// pfre_pkg
// Shared types and constants for the page frame replacement engine.
// ----------------------------------------------------------------------------
`default_nettype none
package pfre_pkg;
	localparam int MAX_FRAMES = 64;
	localparam int FRAME_W    = $clog2(MAX_FRAMES);
	localparam int CNT_W      = $clog2(MAX_FRAMES + 1);
	localparam int ADDR_BITS  = 32;
	localparam int PAGE_W     = 22;
	localparam int STAMP_W    = 32;
	localparam int TOTAL_W    = 32;
	localparam logic [31:0] LFSR_TAPS = 32'h8020_0003;

	localparam logic [1:0] POL_LRU   = 2'd0;
	localparam logic [1:0] POL_FIFO  = 2'd1;
	localparam logic [1:0] POL_RAND  = 2'd2;
	localparam logic [1:0] POL_CLOCK = 2'd3;

	localparam logic [1:0] REG_POLICY = 2'd0;
	localparam logic [1:0] REG_OFFSET = 2'd1;
	localparam logic [1:0] REG_FRAMES = 2'd2;

	// controller to datapath
	typedef struct packed {
		logic load;      // capture request, start hit search
		logic scan_init; // start victim scan: lru, random remainder or clock hand
		logic scan_step; // one scan step
		logic pick_fast; // fifo victim
		logic commit;    // update frame and counters
	} pfre_cmd_t;

	// datapath to controller
	typedef struct packed {
		logic hit;
		logic scan_done;
	} pfre_sts_t;
endpackage
`default_nettype wire

@@ src/pfre_if.sv @@
// ----------------------------------------------------------------------------
// pfre_req_if / pfre_rsp_if
// Valid/ready channels for requests and results.
// ----------------------------------------------------------------------------
`default_nettype none
interface pfre_req_if;
	logic        valid;
	logic        ready;
	logic [31:0] address;
	logic        is_write;
	modport source (output valid, address, is_write, input ready);
	modport sink   (input valid, address, is_write, output ready);
endinterface

interface pfre_rsp_if;
	logic        valid;
	logic        ready;
	logic        fault;
	logic [5:0]  frame;
	logic        evicted_valid;
	logic [21:0] evicted_page;
	logic        evicted_dirty;
	logic [31:0] fault_total;
	logic [31:0] writeback_total;
	logic [31:0] access_total;
	modport source (output valid, fault, frame, evicted_valid, evicted_page, evicted_dirty,
		fault_total, writeback_total, access_total, input ready);
	modport sink (input valid, fault, frame, evicted_valid, evicted_page, evicted_dirty,
		fault_total, writeback_total, access_total, output ready);
endinterface
`default_nettype wire

@@ src/pfre_ctrl.sv @@
// ----------------------------------------------------------------------------
// pfre_ctrl
// Sequencer: hit search, victim selection, commit and result handoff.
// ----------------------------------------------------------------------------
`default_nettype none
module pfre_ctrl
	import pfre_pkg::*;
(
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       req_valid,
	output logic            req_ready,
	output logic            rsp_valid,
	input  wire logic       rsp_ready,
	input  wire logic [1:0] policy,
	input  pfre_sts_t       sts,
	output pfre_cmd_t       cmd
);
	localparam logic [2:0] ST_IDLE   = 3'd0;
	localparam logic [2:0] ST_LOOKUP = 3'd1;
	localparam logic [2:0] ST_SCAN   = 3'd2;
	localparam logic [2:0] ST_COMMIT = 3'd3;
	localparam logic [2:0] ST_OUT    = 3'd4;

	logic [2:0] state_q, state_d;

	always_comb begin
		state_d = state_q;
		cmd = '0;
		req_ready = 1'b0;
		rsp_valid = 1'b0;
		case (state_q)
			ST_IDLE: begin
				req_ready = 1'b1;
				if (req_valid) begin
					cmd.load = 1'b1;
					state_d = ST_LOOKUP;
				end
			end
			ST_LOOKUP: begin
				if (sts.hit) begin
					state_d = ST_COMMIT;
				end else if (policy == POL_FIFO) begin
					cmd.pick_fast = 1'b1;
					state_d = ST_COMMIT;
				end else begin
					cmd.scan_init = 1'b1;
					state_d = ST_SCAN;
				end
			end
			ST_SCAN: begin
				if (sts.scan_done) begin
					state_d = ST_COMMIT;
				end else begin
					cmd.scan_step = 1'b1;
				end
			end
			ST_COMMIT: begin
				cmd.commit = 1'b1;
				state_d = ST_OUT;
			end
			ST_OUT: begin
				rsp_valid = 1'b1;
				req_ready = rsp_ready;
				if (rsp_ready) begin
					if (req_valid) begin
						cmd.load = 1'b1;
						state_d = ST_LOOKUP;
					end else begin
						state_d = ST_IDLE;
					end
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

`ifndef SYNTHESIS
	a_ready_ctl: assert property (@(posedge clk) disable iff (!arst_n)
		req_ready |-> (state_q == ST_IDLE || state_q == ST_OUT))
		else $error("ready outside idle/out");
	a_commit_out: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.commit |=> rsp_valid)
		else $error("commit not followed by result");
	a_scan_state: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.scan_step |-> state_q == ST_SCAN)
		else $error("scan step outside scan");
`endif
endmodule
`default_nettype wire

@@ src/pfre_dp.sv @@
// ----------------------------------------------------------------------------
// pfre_dp
// Frame table, victim scan registers, policy pointers and running counters.
// ----------------------------------------------------------------------------
`default_nettype none
module pfre_dp
	import pfre_pkg::*;
(
	input  wire logic         clk,
	input  wire logic         arst_n,
	input  wire logic         cfg_we,
	input  wire logic [1:0]   cfg_index,
	input  wire logic [6:0]   cfg_data,
	input  pfre_cmd_t         cmd,
	output pfre_sts_t         sts,
	output logic [1:0]        policy,
	input  wire logic [31:0]  in_address,
	input  wire logic         in_is_write,
	output logic              o_fault,
	output logic [5:0]        o_frame,
	output logic              o_ev_valid,
	output logic [21:0]       o_ev_page,
	output logic              o_ev_dirty,
	output logic [31:0]       o_fault_total,
	output logic [31:0]       o_wb_total,
	output logic [31:0]       o_access_total
);
	logic [1:0]  policy_q;
	logic [4:0]  offset_q;
	logic [6:0]  frames_q;

	logic [PAGE_W-1:0]  page_q [MAX_FRAMES];
	logic [STAMP_W-1:0] stamp_mem [MAX_FRAMES];
	logic [MAX_FRAMES-1:0] valid_q, dirty_q, ref_q;

	logic [STAMP_W-1:0] now_q;
	logic [FRAME_W-1:0] fifo_q, hand_q;
	logic [31:0] lfsr_q;
	logic [TOTAL_W-1:0] faults_q, wbs_q, accs_q;

	logic [PAGE_W-1:0]  req_page_q;
	logic               req_wr_q;
	logic               hit_q;
	logic [FRAME_W-1:0] frame_q;
	logic [FRAME_W-1:0] scan_idx_q;
	logic [STAMP_W-1:0] best_stamp_q;
	logic [7:0]         scan_cnt_q;
	logic               done_q;
	logic [31:0]        div_q;
	logic [CNT_W-1:0]   rem_q;
	logic [STAMP_W-1:0] stamp_rd_s1;
	logic               stamp_rdv_s1;

	logic [4:0]        sh;
	logic [31:0]       addr_sh;
	logic [CNT_W-1:0]  n_live;
	logic              hit_c;
	logic [FRAME_W-1:0] hit_idx;
	logic [31:0]       lfsr_nx;
	logic [CNT_W-1:0]  rem_c;
	logic [CNT_W:0]    rem_t;
	logic [FRAME_W-1:0] fifo_cur, hand_cur, scan_nx, hand_nx;
	logic [FRAME_W-1:0] commit_f;
	logic [FRAME_W-1:0] stamp_raddr;
	logic [STAMP_W-1:0] stamp_cur;

	assign policy = policy_q;

	always_comb begin
		sh = offset_q;
		if (offset_q < 5'd10) sh = 5'd10;
		if (offset_q > 5'd30) sh = 5'd30;
		addr_sh = in_address >> sh;
		n_live = frames_q[CNT_W-1:0];
		if (frames_q == 7'd0) n_live = CNT_W'(1);
		if (frames_q > 7'(MAX_FRAMES)) n_live = CNT_W'(MAX_FRAMES);
	end

	// associative match, lowest index wins
	always_comb begin
		hit_c = 1'b0;
		hit_idx = '0;
		for (int i = MAX_FRAMES - 1; i >= 0; i--) begin
			if (valid_q[i] && page_q[i] == req_page_q) begin
				hit_c = 1'b1;
				hit_idx = FRAME_W'(i);
			end
		end
	end

	assign lfsr_nx = lfsr_q[0] ? ((lfsr_q >> 1) ^ LFSR_TAPS) : (lfsr_q >> 1);

	// remainder by frame count, four dividend bits per scan step
	always_comb begin
		rem_c = rem_q;
		rem_t = '0;
		for (int b = 3; b >= 0; b--) begin
			rem_t = {rem_c, div_q[28 + b]};
			if (rem_t >= {1'b0, n_live}) rem_t = rem_t - {1'b0, n_live};
			rem_c = rem_t[CNT_W-1:0];
		end
	end

	always_comb begin
		fifo_cur = ({1'b0, fifo_q} >= n_live) ? '0 : fifo_q;
		hand_cur = ({1'b0, hand_q} >= n_live) ? '0 : hand_q;
		scan_nx = ({1'b0, scan_idx_q} + 1'b1 >= n_live) ? '0 : scan_idx_q + 1'b1;
		hand_nx = ({1'b0, hand_q} + 1'b1 >= n_live) ? '0 : hand_q + 1'b1;
	end

	assign commit_f = hit_q ? hit_idx : frame_q;
	assign stamp_raddr = cmd.scan_init ? '0 : scan_nx;
	// never written frames read as stamp zero
	assign stamp_cur = stamp_rdv_s1 ? stamp_rd_s1 : '0;

	assign sts.hit = hit_c;
	assign sts.scan_done = done_q;

	// stamp ram, one registered read a cycle
	always_ff @(posedge clk) begin
		stamp_rd_s1 <= stamp_mem[stamp_raddr];
		stamp_rdv_s1 <= valid_q[stamp_raddr];
		if (cmd.commit) stamp_mem[commit_f] <= now_q + 1'b1;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			policy_q <= POL_LRU;
			offset_q <= 5'd12;
			frames_q <= 7'd64;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_POLICY: policy_q <= cfg_data[1:0];
				REG_OFFSET: offset_q <= cfg_data[4:0];
				REG_FRAMES: frames_q <= cfg_data;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
			dirty_q <= '0;
			ref_q <= '0;
			now_q <= '0;
			fifo_q <= '0;
			hand_q <= '0;
			lfsr_q <= 32'd1;
			faults_q <= '0;
			wbs_q <= '0;
			accs_q <= '0;
			done_q <= 1'b0;
			req_page_q <= '0;
			req_wr_q <= 1'b0;
			hit_q <= 1'b0;
			frame_q <= '0;
			scan_idx_q <= '0;
			best_stamp_q <= '0;
			scan_cnt_q <= '0;
			div_q <= '0;
			rem_q <= '0;
			o_fault <= 1'b0;
			o_frame <= '0;
			o_ev_valid <= 1'b0;
			o_ev_page <= '0;
			o_ev_dirty <= 1'b0;
			o_fault_total <= '0;
			o_wb_total <= '0;
			o_access_total <= '0;
			for (int i = 0; i < MAX_FRAMES; i++) begin
				page_q[i] <= '0;
			end
		end else begin
			if (cmd.load) begin
				req_page_q <= addr_sh[PAGE_W-1:0];
				req_wr_q <= in_is_write;
			end
			if (cmd.pick_fast) begin
				hit_q <= 1'b0;
				frame_q <= fifo_cur;
				fifo_q <= ({1'b0, fifo_cur} + 1'b1 >= n_live) ? '0 : fifo_cur + 1'b1;
			end
			if (cmd.scan_init) begin
				done_q <= 1'b0;
				scan_cnt_q <= '0;
				scan_idx_q <= '0;
				frame_q <= '0;
				rem_q <= '0;
				if (policy_q == POL_RAND) begin
					lfsr_q <= lfsr_nx;
					div_q <= lfsr_nx;
				end
				if (policy_q == POL_CLOCK) hand_q <= hand_cur;
			end
			if (cmd.scan_step) begin
				if (policy_q == POL_LRU) begin
					if (scan_idx_q == '0 || stamp_cur < best_stamp_q) begin
						best_stamp_q <= stamp_cur;
						frame_q <= scan_idx_q;
					end
					scan_idx_q <= scan_nx;
					if ({1'b0, scan_idx_q} + 1'b1 >= n_live) done_q <= 1'b1;
				end else if (policy_q == POL_RAND) begin
					scan_cnt_q <= scan_cnt_q + 1'b1;
					div_q <= div_q << 4;
					rem_q <= rem_c;
					if (scan_cnt_q == 8'd7) begin
						frame_q <= rem_c[FRAME_W-1:0];
						done_q <= 1'b1;
					end
				end else begin
					scan_cnt_q <= scan_cnt_q + 1'b1;
					hand_q <= hand_nx;
					if (!ref_q[hand_q]) begin
						frame_q <= hand_q;
						done_q <= 1'b1;
					end else if (scan_cnt_q == {n_live, 1'b0}) begin
						frame_q <= '0;
						done_q <= 1'b1;
					end else begin
						ref_q[hand_q] <= 1'b0;
					end
				end
			end
			if (cmd.commit) begin
				o_fault <= !hit_q;
				o_frame <= commit_f;
				o_ev_valid <= 1'b0;
				o_ev_page <= '0;
				o_ev_dirty <= 1'b0;
				accs_q <= accs_q + 1'b1;
				now_q <= now_q + 1'b1;
				o_access_total <= accs_q + 1'b1;
				o_fault_total <= hit_q ? faults_q : faults_q + 1'b1;
				o_wb_total <= wbs_q;
				if (!hit_q) begin
					faults_q <= faults_q + 1'b1;
					if (valid_q[commit_f]) begin
						o_ev_valid <= 1'b1;
						o_ev_page <= page_q[commit_f];
						o_ev_dirty <= dirty_q[commit_f];
						if (dirty_q[commit_f]) begin
							wbs_q <= wbs_q + 1'b1;
							o_wb_total <= wbs_q + 1'b1;
						end
					end
					page_q[commit_f] <= req_page_q;
					valid_q[commit_f] <= 1'b1;
				end
				ref_q[commit_f] <= 1'b1;
				dirty_q[commit_f] <= req_wr_q | (hit_q & dirty_q[commit_f]);
			end
			// hit flag sampled in the cycle after load
			if (!cmd.pick_fast && !cmd.scan_step && !cmd.scan_init && !cmd.commit
				&& !cmd.load) begin
				hit_q <= hit_c;
			end
			if (cmd.scan_init) hit_q <= 1'b0;
		end
	end

`ifndef SYNTHESIS
	a_hand_range: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.scan_step && policy_q == POL_CLOCK) |-> {1'b0, hand_q} < n_live)
		else $error("clock hand beyond frame count");
	a_commit_valid: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.commit |=> valid_q[o_frame[FRAME_W-1:0]])
		else $error("committed frame not valid");
	a_fault_count: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.commit |=> (faults_q == $past(faults_q) + 32'(!$past(hit_q))))
		else $error("fault count mismatch");
`endif
endmodule
`default_nettype wire

@@ src/page_frame_replacement_engine.sv @@
// ----------------------------------------------------------------------------
// page_frame_replacement_engine
// Page lookup and victim selection for one memory access per request.
// ----------------------------------------------------------------------------
// One request at a time. A hit or a FIFO miss goes from the lookup state
// straight to commit and then to the result state. A random miss forms the
// remainder of the LFSR value by the frame count four bits a cycle.
// An LRU miss reads one frame stamp a cycle from the stamp RAM; a clock miss
// sweeps one frame a cycle and always ends, since one full turn clears every
// referenced bit. The next request is taken in the cycle the result is taken;
// a stalled result holds it off.
`default_nettype none
module page_frame_replacement_engine
	import pfre_pkg::*;
(
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       cfg_we,
	input  wire logic [1:0] cfg_index,
	input  wire logic [6:0] cfg_data,
	pfre_req_if.sink        req,
	pfre_rsp_if.source      rsp
);
	pfre_cmd_t  cmd;
	pfre_sts_t  sts;
	logic [1:0] policy;

	pfre_ctrl u_ctrl (
		.clk, .arst_n,
		.req_valid(req.valid), .req_ready(req.ready),
		.rsp_valid(rsp.valid), .rsp_ready(rsp.ready),
		.policy, .sts, .cmd
	);

	pfre_dp u_dp (
		.clk, .arst_n, .cfg_we, .cfg_index, .cfg_data,
		.cmd, .sts, .policy,
		.in_address(req.address), .in_is_write(req.is_write),
		.o_fault(rsp.fault), .o_frame(rsp.frame),
		.o_ev_valid(rsp.evicted_valid), .o_ev_page(rsp.evicted_page),
		.o_ev_dirty(rsp.evicted_dirty), .o_fault_total(rsp.fault_total),
		.o_wb_total(rsp.writeback_total), .o_access_total(rsp.access_total)
	);
endmodule
`default_nettype wire

@@ dv/pfre_tb_if.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// pfre_tb_if
// Note: the request and result channels are the interfaces of src/pfre_if.sv;
// this file only holds a small bundle for the configuration write port.
// ----------------------------------------------------------------------------
interface pfre_cfg_bus;
	logic       we;
	logic [1:0] index;
	logic [6:0] data;
	modport source (output we, index, data);
	modport sink (input we, index, data);
endinterface

@@ dv/pfre_checker.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// pfre_checker
// Watches the config port and both channels, keeps its own copy of the frame
// table and replacement state, predicts each result and compares it.
// ----------------------------------------------------------------------------
module pfre_checker
	import pfre_pkg::*;
(
	input  logic clk,
	input  logic arst_n,
	pfre_cfg_bus.sink cfg,
	input  logic req_valid,
	input  logic req_ready,
	input  logic [31:0] req_address,
	input  logic req_is_write,
	input  logic rsp_valid,
	input  logic rsp_ready,
	input  logic rsp_fault,
	input  logic [5:0] rsp_frame,
	input  logic rsp_evicted_valid,
	input  logic [21:0] rsp_evicted_page,
	input  logic rsp_evicted_dirty,
	input  logic [31:0] rsp_fault_total,
	input  logic [31:0] rsp_writeback_total,
	input  logic [31:0] rsp_access_total,
	output int   errors,
	output int   pending,
	output int   faults_seen,
	output int   evictions_seen
);
	typedef struct packed {
		logic        fault;
		logic [5:0]  frame;
		logic        ev_valid;
		logic [21:0] ev_page;
		logic        ev_dirty;
		logic [31:0] faults;
		logic [31:0] writebacks;
		logic [31:0] accesses;
	} access_result_t;

	access_result_t expected_results[$];

	logic [1:0]  cur_policy;
	logic [4:0]  cur_offset;
	logic [6:0]  cur_frames;
	logic [21:0] pg_tab[MAX_FRAMES];
	logic        vld_tab[MAX_FRAMES];
	logic        drt_tab[MAX_FRAMES];
	logic        ref_tab[MAX_FRAMES];
	logic [31:0] stamp_tab[MAX_FRAMES];
	logic [31:0] now_ctr, lfsr, n_faults, n_wb, n_acc;
	int          fifo_ptr, hand;

	assign pending = expected_results.size();

	function automatic int choose_victim(int n);
		int v;
		case (cur_policy)
			POL_LRU: begin
				v = 0;
				for (int i = 1; i < n; i++)
					if (stamp_tab[i] < stamp_tab[v]) v = i;
				return v;
			end
			POL_FIFO: begin
				if (fifo_ptr >= n) fifo_ptr = 0;
				v = fifo_ptr;
				fifo_ptr = (v + 1) % n;
				return v;
			end
			POL_RAND: begin
				lfsr = lfsr[0] ? ((lfsr >> 1) ^ LFSR_TAPS) : (lfsr >> 1);
				return int'(lfsr % n);
			end
			default: begin
				if (hand >= n) hand = 0;
				for (int i = 0; i < 2 * n + 1; i++) begin
					v = hand;
					hand = (v + 1) % n;
					if (!ref_tab[v]) return v;
					ref_tab[v] = 1'b0;
				end
				return 0;
			end
		endcase
	endfunction

	function automatic access_result_t predict_access(logic [31:0] addr, logic wr);
		access_result_t r;
		int sh, n, f;
		logic [21:0] page;
		logic hit;
		r = '0;
		sh = cur_offset;
		if (sh < 10) sh = 10;
		if (sh > 30) sh = 30;
		page = 22'((addr >> sh) & 32'h3F_FFFF);
		n_acc++;
		now_ctr++;
		hit = 1'b0;
		f = 0;
		for (int i = 0; i < MAX_FRAMES; i++)
			if (!hit && vld_tab[i] && pg_tab[i] == page) begin
				f = i;
				hit = 1'b1;
			end
		if (!hit) begin
			n_faults++;
			n = cur_frames;
			if (n < 1) n = 1;
			if (n > MAX_FRAMES) n = MAX_FRAMES;
			f = choose_victim(n);
			if (vld_tab[f]) begin
				r.ev_valid = 1'b1;
				r.ev_page = pg_tab[f];
				r.ev_dirty = drt_tab[f];
				if (drt_tab[f]) n_wb++;
			end
			pg_tab[f] = page;
			vld_tab[f] = 1'b1;
			drt_tab[f] = 1'b0;
		end
		ref_tab[f] = 1'b1;
		stamp_tab[f] = now_ctr;
		if (wr) drt_tab[f] = 1'b1;
		r.fault = !hit;
		r.frame = 6'(f);
		r.faults = n_faults;
		r.writebacks = n_wb;
		r.accesses = n_acc;
		return r;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		access_result_t e;
		if (!arst_n) begin
			cur_policy = POL_LRU;
			cur_offset = 5'd12;
			cur_frames = 7'd64;
			for (int i = 0; i < MAX_FRAMES; i++) begin
				pg_tab[i] = '0;
				vld_tab[i] = 1'b0;
				drt_tab[i] = 1'b0;
				ref_tab[i] = 1'b0;
				stamp_tab[i] = '0;
			end
			now_ctr = '0;
			lfsr = 32'd1;
			n_faults = '0;
			n_wb = '0;
			n_acc = '0;
			fifo_ptr = 0;
			hand = 0;
			errors = 0;
			faults_seen = 0;
			evictions_seen = 0;
			expected_results.delete();
		end else begin
			if (cfg.we) begin
				case (cfg.index)
					REG_POLICY: cur_policy = cfg.data[1:0];
					REG_OFFSET: cur_offset = cfg.data[4:0];
					REG_FRAMES: cur_frames = cfg.data;
					default: ;
				endcase
			end
			if (rsp_valid && rsp_ready) begin
				if (expected_results.size() == 0) begin
					$error("result with no request outstanding");
					errors++;
				end else begin
					e = expected_results.pop_front();
					if (rsp_fault !== e.fault) begin
						$error("fault exp %0d got %0d", e.fault, rsp_fault); errors++;
					end
					if (rsp_frame !== e.frame) begin
						$error("frame exp %0d got %0d", e.frame, rsp_frame); errors++;
					end
					if (rsp_evicted_valid !== e.ev_valid) begin
						$error("evicted_valid exp %0d got %0d", e.ev_valid, rsp_evicted_valid);
						errors++;
					end
					if (rsp_evicted_page !== e.ev_page) begin
						$error("evicted_page exp %h got %h", e.ev_page, rsp_evicted_page);
						errors++;
					end
					if (rsp_evicted_dirty !== e.ev_dirty) begin
						$error("evicted_dirty exp %0d got %0d", e.ev_dirty, rsp_evicted_dirty);
						errors++;
					end
					if (rsp_fault_total !== e.faults) begin
						$error("fault_total exp %0d got %0d", e.faults, rsp_fault_total);
						errors++;
					end
					if (rsp_writeback_total !== e.writebacks) begin
						$error("writeback_total exp %0d got %0d", e.writebacks,
							rsp_writeback_total);
						errors++;
					end
					if (rsp_access_total !== e.accesses) begin
						$error("access_total exp %0d got %0d", e.accesses, rsp_access_total);
						errors++;
					end
					if (e.fault) faults_seen++;
					if (e.ev_valid) evictions_seen++;
				end
			end
			if (req_valid && req_ready)
				expected_results.push_back(predict_access(req_address, req_is_write));
		end
	end
endmodule

@@ dv/tb_page_frame_replacement_engine.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_page_frame_replacement_engine
// Drives memory accesses under every policy and a spread of page sizes and
// frame counts, extremes included, with random stalls on both channels; the
// checker predicts each result.
module tb_page_frame_replacement_engine
	import pfre_pkg::*;
();
	localparam int WATCHDOG = 20000;

	logic clk;
	logic arst_n;
	logic cfg_we;
	logic [1:0] cfg_index;
	logic [6:0] cfg_data;
	int   send_idle_pct, recv_idle_pct;
	int   errors, pending, faults_seen, evictions_seen;
	int   idle_cycles, sent;
	bit   timed_out;
	logic [31:0] page_pool[16];

	pfre_req_if req();
	pfre_rsp_if rsp();
	pfre_cfg_bus cfg();

	assign cfg.we = cfg_we;
	assign cfg.index = cfg_index;
	assign cfg.data = cfg_data;

	page_frame_replacement_engine dut (
		.clk(clk), .arst_n(arst_n),
		.cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
		.req(req.sink), .rsp(rsp.source)
	);

	pfre_checker checker_i (
		.clk(clk), .arst_n(arst_n), .cfg(cfg.sink),
		.req_valid(req.valid), .req_ready(req.ready),
		.req_address(req.address), .req_is_write(req.is_write),
		.rsp_valid(rsp.valid), .rsp_ready(rsp.ready),
		.rsp_fault(rsp.fault), .rsp_frame(rsp.frame),
		.rsp_evicted_valid(rsp.evicted_valid), .rsp_evicted_page(rsp.evicted_page),
		.rsp_evicted_dirty(rsp.evicted_dirty), .rsp_fault_total(rsp.fault_total),
		.rsp_writeback_total(rsp.writeback_total), .rsp_access_total(rsp.access_total),
		.errors(errors), .pending(pending),
		.faults_seen(faults_seen), .evictions_seen(evictions_seen)
	);

	always begin
		clk = 1'b0; #6;
		clk = 1'b1; #6;
	end

	// random result stalls
	always @(negedge clk) begin
		rsp.ready <= ($urandom_range(99) >= recv_idle_pct);
	end

	// watchdog on cycles without any transfer
	always @(posedge clk) begin
		if ((req.valid && req.ready) || (rsp.valid && rsp.ready)) idle_cycles <= 0;
		else idle_cycles <= idle_cycles + 1;
		if (idle_cycles > WATCHDOG && !timed_out) begin
			timed_out = 1'b1;
			$display("Verification failed");
			$finish;
		end
	end

	task automatic write_reg(input logic [1:0] idx, input logic [6:0] val);
		@(negedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(negedge clk);
		cfg_we <= 1'b0;
	endtask

	task automatic wait_drained();
		req.valid <= 1'b0;
		while (pending != 0) @(negedge clk);
		repeat (10) @(negedge clk);
	endtask

	task automatic send_access(input logic [31:0] addr, input logic wr);
		while ($urandom_range(99) < send_idle_pct) begin
			req.valid <= 1'b0;
			@(negedge clk);
		end
		req.valid <= 1'b1;
		req.address <= addr;
		req.is_write <= wr;
		@(posedge clk);
		while (!req.ready) @(posedge clk);
		sent++;
		@(negedge clk);
	endtask

	task automatic set_config(input logic [1:0] pol, input logic [6:0] offs,
			input logic [6:0] nfr);
		wait_drained();
		write_reg(REG_POLICY, {5'b0, pol});
		write_reg(REG_OFFSET, offs);
		write_reg(REG_FRAMES, nfr);
	endtask

	// mostly reuses a small working set so hits and evictions both happen
	task automatic random_phase(input int count);
		logic [31:0] a;
		for (int i = 0; i < count; i++) begin
			if ($urandom_range(9) < 8) a = page_pool[$urandom_range(15)] ^ $urandom_range(1023);
			else a = $urandom();
			send_access(a, 1'($urandom_range(1)));
		end
	endtask

	initial begin
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_index = '0;
		cfg_data = '0;
		req.valid = 1'b0;
		req.address = '0;
		req.is_write = 1'b0;
		rsp.ready = 1'b0;
		send_idle_pct = 33;
		recv_idle_pct = 48;
		idle_cycles = 0;
		sent = 0;
		timed_out = 1'b0;
		repeat (5) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// directed: reset config, address extremes, hit, dirty eviction
		send_access(32'h0000_0000, 1'b0);
		send_access(32'hFFFF_FFFF, 1'b1);
		send_access(32'h0000_0FFF, 1'b1);
		send_access(32'hFFFF_F000, 1'b0);
		set_config(POL_FIFO, 7'd10, 7'd2);
		send_access(32'h0000_0400, 1'b1);
		send_access(32'h0000_0800, 1'b0);
		send_access(32'h0000_0C00, 1'b1);
		send_access(32'h0000_0400, 1'b0);
		set_config(POL_RAND, 7'd30, 7'd0);
		send_access(32'h4000_0000, 1'b1);
		send_access(32'hC000_0000, 1'b0);
		send_access(32'h8000_0000, 1'b0);
		set_config(POL_CLOCK, 7'd31, 7'd3);
		for (int i = 0; i < 6; i++) send_access(32'(i % 4) << 30, i[0]);
		set_config(POL_LRU, 7'd5, 7'd127);
		send_access(32'h0000_0000, 1'b0);
		send_access(32'h5555_5555, 1'b1);
		send_access(32'hAAAA_AAAA, 1'b0);
		set_config(POL_FIFO, 7'd12, 7'd1);
		send_access(32'h1234_5000, 1'b1);
		send_access(32'h1234_6000, 1'b0);

		for (int phase = 0; phase < 12; phase++) begin
			if (phase == 4) begin
				send_idle_pct = 48;
				recv_idle_pct = 33;
			end else if (phase == 8) begin
				send_idle_pct = 0;
				recv_idle_pct = 0;
			end
			foreach (page_pool[k]) page_pool[k] = $urandom();
			set_config(2'(phase % 4), 7'($urandom_range(9, 31)),
				(phase % 3 == 0) ? 7'd64 : 7'($urandom_range(1, 16)));
			random_phase(50);
		end

		wait_drained();
		$display("%0d accesses sent, %0d faults, %0d evictions checked", sent, faults_seen,
			evictions_seen);
		$display("all four policies, page sizes and frame counts including extremes");
		if (errors == 0) $display("Verification passed");
		else $display("Verification failed");
		$finish;
	end
endmodule
